@@ hdl/ordered_frame_filter_rule_table_top_macros.svh @@
// Assertion macros for the frame filter rule table.
// Used by the top level only; define ASSERT_OFF to compile them out.
`ifndef ORDERED_FRAME_FILTER_RULE_TABLE_TOP_MACROS_SVH
`define ORDERED_FRAME_FILTER_RULE_TABLE_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define OFFRT_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);
`define OFFRT_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);
`else
`define OFFRT_ASSERT_IMP(lbl, ck, rn, ante, cons, msg)
`define OFFRT_ASSERT_NXT(lbl, ck, rn, ante, cons, msg)
`endif
`endif

@@ hdl/offrt_pkg.sv @@
// Types, codes and the rule match function of the frame filter rule table.
// No dependencies.
`default_nettype none
package offrt_pkg;

  typedef enum logic [2:0] {
    FN_CHECK  = 3'd0,
    FN_APPEND = 3'd1,
    FN_OVER   = 3'd2,
    FN_ENABLE = 3'd3,
    FN_REMOVE = 3'd4,
    FN_CLEAR  = 3'd5
  } func_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [15:0] IPV4_TYPE = 16'h0800;

  localparam int M_PORT  = 0;
  localparam int M_DIR   = 1;
  localparam int M_SMAC  = 2;
  localparam int M_DMAC  = 3;
  localparam int M_ETYPE = 4;
  localparam int M_SIP   = 5;
  localparam int M_DIP   = 6;
  localparam int M_PROTO = 7;
  localparam int M_APP   = 8;
  localparam int C_EN    = 9;
  localparam int C_ALLOW = 10;
  localparam int C_IDX   = 11;
  localparam int IDX_W   = 6;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_SHIFT,
    S_ENA,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [16:0] rule_control;
    logic [7:0]  port;
    logic        direction;
    logic [47:0] src_mac;
    logic [47:0] dst_mac;
    logic [15:0] ether_type;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [7:0]  ip_proto;
    logic [15:0] l4_src_port;
    logic [15:0] l4_dst_port;
  } req_t;

  typedef struct packed {
    logic       allowed;
    logic [1:0] status;
    logic [6:0] rule_total;
  } rsp_t;

  typedef struct packed {
    logic [8:0]  mask;
    logic        enabled;
    logic        allow;
    logic [7:0]  port;
    logic        direction;
    logic [15:0] ether_type;
    logic [7:0]  ip_proto;
    logic [15:0] app_port;
    logic [47:0] src_mac;
    logic [47:0] dst_mac;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
  } rule_t;

  function automatic rule_t make_rule(req_t q);
    rule_t r;
    r.mask       = q.rule_control[8:0];
    r.enabled    = q.rule_control[C_EN];
    r.allow      = q.rule_control[C_ALLOW];
    r.port       = q.port;
    r.direction  = q.direction;
    r.ether_type = q.ether_type;
    r.ip_proto   = q.ip_proto;
    r.app_port   = q.l4_dst_port;
    r.src_mac    = q.src_mac;
    r.dst_mac    = q.dst_mac;
    r.src_ip     = q.src_ip;
    r.dst_ip     = q.dst_ip;
    return r;
  endfunction

  function automatic logic rule_hit(rule_t r, req_t q);
    logic hit;
    hit = r.enabled;
    if (r.mask[M_PORT] && r.port != q.port) hit = 1'b0;
    if (r.mask[M_DIR] && r.direction != q.direction) hit = 1'b0;
    if (r.mask[M_SMAC] && r.src_mac != q.src_mac) hit = 1'b0;
    if (r.mask[M_DMAC] && r.dst_mac != q.dst_mac) hit = 1'b0;
    if (r.mask[M_ETYPE]) begin
      if (r.ether_type != q.ether_type) hit = 1'b0;
      // IP fields count only for IPv4 rules
      if (r.ether_type == IPV4_TYPE) begin
        if (r.mask[M_SIP] && r.src_ip != q.src_ip) hit = 1'b0;
        if (r.mask[M_DIP] && r.dst_ip != q.dst_ip) hit = 1'b0;
        if (r.mask[M_PROTO] && r.ip_proto != q.ip_proto) hit = 1'b0;
        if (r.mask[M_APP] && r.app_port != q.l4_src_port &&
            r.app_port != q.l4_dst_port) hit = 1'b0;
      end
    end
    return hit;
  endfunction

endpackage
`default_nettype wire

@@ hdl/offrt_if.sv @@
// Request and result channel interfaces of the frame filter rule table.
// Depends on offrt_pkg.
`default_nettype none
interface offrt_req_if;
  logic              valid;
  logic              ready;
  offrt_pkg::req_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface offrt_rsp_if;
  logic              valid;
  logic              ready;
  offrt_pkg::rsp_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hdl/ordered_frame_filter_rule_table_top.sv @@
// Channel  | Dir | Handshake   | Payload
// in_if    | in  | valid/ready | offrt_pkg::req_t (command or frame)
// out_if   | out | valid/ready | offrt_pkg::rsp_t (verdict, status, count)
//
// A check scans the table: it reads one rule per cycle from the rule memory
// (one write port, one registered read port), then drains the last read.
// Remove moves one shifted rule per cycle; set enabled reads the rule, then
// writes it back with the new enable bit.
// Reset clears the count and control; the rule memory is not cleared.
// A new request is taken while a result waits in the output register; the next
// result holds until that one is taken.
// Depends on offrt_pkg, offrt_if and the macros header.
`default_nettype none
`include "ordered_frame_filter_rule_table_top_macros.svh"
module ordered_frame_filter_rule_table_top #(
  parameter int MAX_RULES = 64
) (
  input  wire         clk,
  input  wire         rst_n,
  offrt_req_if.sink   in_if,
  offrt_rsp_if.source out_if
);

  localparam int AW   = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int CW   = $clog2(MAX_RULES + 1);
  localparam int CMPW = CW + offrt_pkg::IDX_W;

  offrt_pkg::state_t state_r, state_nxt;
  offrt_pkg::req_t   req_r;
  offrt_pkg::rule_t  mem [MAX_RULES];
  offrt_pkg::rule_t  rd_data_r;
  offrt_pkg::rule_t  wd;
  offrt_pkg::rsp_t   out_data_r, out_data_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [AW-1:0]     rd_addr_r, rd_addr_nxt;
  logic [AW-1:0]     ra, wa;
  logic              we;
  logic              rd_vld_r, rd_vld_nxt;
  logic              allow_r, allow_nxt;
  logic [1:0]        status_r, status_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CMPW-1:0]   idx_ext;
  logic              idx_bad;
  logic              more;
  logic              out_free;
  logic              accept;
  logic [CW+6:0]     tot_ext;

  assign accept   = in_if.valid && in_if.ready;
  assign idx_ext  = CMPW'(req_r.rule_control[offrt_pkg::C_IDX +: offrt_pkg::IDX_W]);
  assign idx_bad  = idx_ext >= CMPW'(cnt_r);
  assign more     = idx_r < cnt_r;
  assign out_free = !out_valid_r || out_if.ready;
  assign tot_ext  = (CW + 7)'(cnt_r);

  assign in_if.ready  = (state_r == offrt_pkg::S_IDLE);
  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_data_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      offrt_pkg::S_IDLE: begin
        if (accept) state_nxt = offrt_pkg::S_EXEC;
      end
      offrt_pkg::S_EXEC: begin
        state_nxt = offrt_pkg::S_RESP;
        if (req_r.func == offrt_pkg::FN_CHECK) state_nxt = offrt_pkg::S_SCAN;
        if (req_r.func == offrt_pkg::FN_REMOVE && !idx_bad) state_nxt = offrt_pkg::S_SHIFT;
        if (req_r.func == offrt_pkg::FN_ENABLE && !idx_bad) state_nxt = offrt_pkg::S_ENA;
      end
      offrt_pkg::S_SCAN, offrt_pkg::S_SHIFT: begin
        if (!more && !rd_vld_r) state_nxt = offrt_pkg::S_RESP;
      end
      offrt_pkg::S_ENA: state_nxt = offrt_pkg::S_RESP;
      offrt_pkg::S_RESP: begin
        if (out_free) state_nxt = offrt_pkg::S_IDLE;
      end
      default: state_nxt = offrt_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    we            = 1'b0;
    wa            = idx_ext[AW-1:0];
    wd            = offrt_pkg::make_rule(req_r);
    ra            = idx_r[AW-1:0];
    rd_vld_nxt    = 1'b0;
    rd_addr_nxt   = rd_addr_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    allow_nxt     = allow_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_data_nxt  = out_data_r;
    case (state_r)
      offrt_pkg::S_EXEC: begin
        allow_nxt  = 1'b1;
        status_nxt = offrt_pkg::ST_OK;
        case (req_r.func)
          offrt_pkg::FN_CHECK: idx_nxt = '0;
          offrt_pkg::FN_APPEND: begin
            if (cnt_r == CW'(MAX_RULES)) begin
              status_nxt = offrt_pkg::ST_FULL;
            end else begin
              we      = 1'b1;
              wa      = cnt_r[AW-1:0];
              cnt_nxt = cnt_r + 1'b1;
            end
          end
          offrt_pkg::FN_OVER: begin
            if (idx_bad) status_nxt = offrt_pkg::ST_RANGE;
            else we = 1'b1;
          end
          offrt_pkg::FN_ENABLE: begin
            if (idx_bad) begin
              status_nxt = offrt_pkg::ST_RANGE;
            end else begin
              ra          = idx_ext[AW-1:0];
              rd_vld_nxt  = 1'b1;
              rd_addr_nxt = idx_ext[AW-1:0];
            end
          end
          offrt_pkg::FN_REMOVE: begin
            if (idx_bad) status_nxt = offrt_pkg::ST_RANGE;
            else idx_nxt = idx_ext[CW-1:0] + 1'b1;
          end
          offrt_pkg::FN_CLEAR: cnt_nxt = '0;
          default: ;
        endcase
      end
      offrt_pkg::S_SCAN: begin
        if (more) begin
          rd_vld_nxt = 1'b1;
          idx_nxt    = idx_r + 1'b1;
        end
        // last matching rule wins
        if (rd_vld_r && offrt_pkg::rule_hit(rd_data_r, req_r)) allow_nxt = rd_data_r.allow;
      end
      offrt_pkg::S_SHIFT: begin
        if (more) begin
          rd_vld_nxt  = 1'b1;
          rd_addr_nxt = idx_r[AW-1:0];
          idx_nxt     = idx_r + 1'b1;
        end
        // move each later rule down one place
        if (rd_vld_r) begin
          we = 1'b1;
          wa = rd_addr_r - 1'b1;
          wd = rd_data_r;
        end
        if (!more && !rd_vld_r) cnt_nxt = cnt_r - 1'b1;
      end
      offrt_pkg::S_ENA: begin
        we         = 1'b1;
        wa         = rd_addr_r;
        wd         = rd_data_r;
        wd.enabled = req_r.rule_control[offrt_pkg::C_EN];
      end
      offrt_pkg::S_RESP: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.allowed    = allow_r;
          out_data_nxt.status     = status_r;
          out_data_nxt.rule_total = tot_ext[6:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= offrt_pkg::S_IDLE;
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) req_r <= in_if.data;
    idx_r      <= idx_nxt;
    rd_addr_r  <= rd_addr_nxt;
    allow_r    <= allow_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

  // rule memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_data_r <= mem[ra];
  end

  `OFFRT_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CW'(MAX_RULES), "rule count above table size")
  `OFFRT_ASSERT_NXT(a_accept_exec, clk, rst_n, accept, state_r == offrt_pkg::S_EXEC, "request not dispatched")
  `OFFRT_ASSERT_IMP(a_rd_state, clk, rst_n, rd_vld_r, state_r == offrt_pkg::S_SCAN || state_r == offrt_pkg::S_SHIFT || state_r == offrt_pkg::S_ENA, "read data outside a memory walk")

endmodule
`default_nettype wire

@@ verif/ordered_frame_filter_rule_table_top_tb.sv @@
// Self-checking bench for the frame filter rule table top level.
// Depends on offrt_pkg, offrt_if and the rule table RTL.
`default_nettype none
module ordered_frame_filter_rule_table_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = 64;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #2 clk = ~clk;

  offrt_req_if in_if ();
  offrt_rsp_if out_if ();

  ordered_frame_filter_rule_table_top #(.MAX_RULES(TABLE_DEPTH)) dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_if.sink), .out_if(out_if.source)
  );

  // Shadow copy of the rule table
  offrt_pkg::rule_t shadow_rules[TABLE_DEPTH];
  int unsigned shadow_count;
  offrt_pkg::rsp_t verdict_q[$];
  int unsigned mismatches;
  int unsigned requests_sent;
  int unsigned results_seen;
  int unsigned cycle_count;
  bit quiet_mode;

  function automatic logic shadow_hit(offrt_pkg::rule_t r, offrt_pkg::req_t q);
    if (!r.enabled) return 1'b0;
    if (r.mask[offrt_pkg::M_PORT] && r.port != q.port) return 1'b0;
    if (r.mask[offrt_pkg::M_DIR] && r.direction != q.direction) return 1'b0;
    if (r.mask[offrt_pkg::M_SMAC] && r.src_mac != q.src_mac) return 1'b0;
    if (r.mask[offrt_pkg::M_DMAC] && r.dst_mac != q.dst_mac) return 1'b0;
    if (r.mask[offrt_pkg::M_ETYPE]) begin
      if (r.ether_type != q.ether_type) return 1'b0;
      if (r.ether_type == offrt_pkg::IPV4_TYPE) begin
        if (r.mask[offrt_pkg::M_SIP] && r.src_ip != q.src_ip) return 1'b0;
        if (r.mask[offrt_pkg::M_DIP] && r.dst_ip != q.dst_ip) return 1'b0;
        if (r.mask[offrt_pkg::M_PROTO] && r.ip_proto != q.ip_proto) return 1'b0;
        if (r.mask[offrt_pkg::M_APP] && r.app_port != q.l4_src_port &&
            r.app_port != q.l4_dst_port) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic offrt_pkg::rule_t rule_from_request(offrt_pkg::req_t q);
    offrt_pkg::rule_t r;
    r.mask = q.rule_control[8:0];
    r.enabled = q.rule_control[offrt_pkg::C_EN];
    r.allow = q.rule_control[offrt_pkg::C_ALLOW];
    r.port = q.port;
    r.direction = q.direction;
    r.ether_type = q.ether_type;
    r.ip_proto = q.ip_proto;
    r.app_port = q.l4_dst_port;
    r.src_mac = q.src_mac;
    r.dst_mac = q.dst_mac;
    r.src_ip = q.src_ip;
    r.dst_ip = q.dst_ip;
    return r;
  endfunction

  function automatic offrt_pkg::rsp_t apply_to_table(offrt_pkg::req_t q);
    offrt_pkg::rsp_t o;
    int unsigned idx;
    idx = 32'(q.rule_control[offrt_pkg::C_IDX +: offrt_pkg::IDX_W]);
    o.allowed = 1'b1;
    o.status = offrt_pkg::ST_OK;
    case (q.func)
      offrt_pkg::FN_CHECK: begin
        for (int k = 0; k < shadow_count; k++)
          if (shadow_hit(shadow_rules[k], q)) o.allowed = shadow_rules[k].allow;
      end
      offrt_pkg::FN_APPEND: begin
        if (shadow_count >= TABLE_DEPTH) o.status = offrt_pkg::ST_FULL;
        else begin
          shadow_rules[shadow_count] = rule_from_request(q);
          shadow_count++;
        end
      end
      offrt_pkg::FN_OVER: begin
        if (idx >= shadow_count) o.status = offrt_pkg::ST_RANGE;
        else shadow_rules[idx] = rule_from_request(q);
      end
      offrt_pkg::FN_ENABLE: begin
        if (idx >= shadow_count) o.status = offrt_pkg::ST_RANGE;
        else shadow_rules[idx].enabled = q.rule_control[offrt_pkg::C_EN];
      end
      offrt_pkg::FN_REMOVE: begin
        if (idx >= shadow_count) o.status = offrt_pkg::ST_RANGE;
        else begin
          for (int k = idx; k + 1 < shadow_count; k++)
            shadow_rules[k] = shadow_rules[k + 1];
          shadow_count--;
        end
      end
      offrt_pkg::FN_CLEAR: shadow_count = 0;
      default: ;
    endcase
    o.rule_total = shadow_count[6:0];
    return o;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    mismatches++;
    $display("[%0t] result %0d: %s got %0d expected %0d", $realtime, results_seen,
             what, got, want);
  endtask

  // Sender: random gap, then hold the request until taken; returns at a falling edge
  task automatic send_request(offrt_pkg::req_t q);
    if (!quiet_mode && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data <= q;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    verdict_q.push_back(apply_to_table(q));
    requests_sent++;
    @(negedge clk);
  endtask

  // Receiver stalls
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (quiet_mode || $urandom_range(0, 4) != 0) out_if.ready <= 1'b1;
      else begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      results_seen++;
      if (verdict_q.size() == 0) report_mismatch("unexpected result", 1, 0);
      else begin
        offrt_pkg::rsp_t w;
        w = verdict_q.pop_front();
        if (out_if.data.allowed !== w.allowed)
          report_mismatch("allowed", out_if.data.allowed, w.allowed);
        if (out_if.data.status !== w.status)
          report_mismatch("status", out_if.data.status, w.status);
        if (out_if.data.rule_total !== w.rule_total)
          report_mismatch("rule_total", out_if.data.rule_total, w.rule_total);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic offrt_pkg::req_t random_request(offrt_pkg::func_t f);
    offrt_pkg::req_t q;
    q.func = f;
    q.rule_control = 17'($urandom_range(0, 17'h1ffff));
    q.port = 8'($urandom_range(0, 3));
    q.direction = 1'($urandom_range(0, 1));
    q.src_mac = {$urandom_range(0, 1) ? 16'hffff : 16'h0, 30'h0, 2'($urandom_range(0, 3))};
    q.dst_mac = {$urandom, 16'($urandom)};
    if ($urandom_range(0, 2) != 0) q.dst_mac = 48'h0000_0000_000a;
    q.ether_type = $urandom_range(0, 3) != 0 ? offrt_pkg::IPV4_TYPE :
                   16'($urandom_range(0, 1) ? 16'h86dd : $urandom);
    q.src_ip = $urandom_range(0, 1) ? 32'hc0a8_0001 : $urandom;
    q.dst_ip = $urandom_range(0, 1) ? 32'h0a00_0001 : $urandom;
    q.ip_proto = $urandom_range(0, 1) ? 8'd6 : 8'($urandom);
    q.l4_src_port = $urandom_range(0, 1) ? 16'd80 : 16'($urandom);
    q.l4_dst_port = $urandom_range(0, 1) ? 16'd443 : 16'($urandom);
    if ($urandom_range(0, 1)) q.l4_dst_port = 16'd80;
    return q;
  endfunction

  task automatic test_directed_commands();
    offrt_pkg::req_t q;
    q = random_request(offrt_pkg::FN_CHECK);
    send_request(q);
    q = random_request(offrt_pkg::FN_REMOVE);
    q.rule_control[offrt_pkg::C_IDX +: offrt_pkg::IDX_W] = '0;
    send_request(q);
    q = random_request(offrt_pkg::FN_APPEND);
    q.rule_control = '1;
    q.port = 8'hff; q.src_mac = '1; q.dst_mac = '1; q.ether_type = offrt_pkg::IPV4_TYPE;
    q.src_ip = '1; q.dst_ip = '1; q.ip_proto = '1; q.l4_src_port = '1;
    q.l4_dst_port = '1;
    send_request(q);
    q.func = offrt_pkg::FN_CHECK; q.l4_dst_port = 16'h0;
    send_request(q);
    q.l4_src_port = 16'h0;
    send_request(q);
    q = '0; q.func = offrt_pkg::FN_APPEND; q.rule_control[offrt_pkg::C_EN] = 1'b1;
    send_request(q);
    q.func = offrt_pkg::FN_CHECK;
    send_request(q);
    q.func = offrt_pkg::FN_ENABLE; q.rule_control = '0;
    q.rule_control[offrt_pkg::C_IDX +: offrt_pkg::IDX_W] = 6'd1;
    send_request(q);
    q.rule_control[offrt_pkg::C_IDX +: offrt_pkg::IDX_W] = 6'h3f;
    send_request(q);
    q.func = offrt_pkg::FN_OVER;
    send_request(q);
    q.func = offrt_pkg::FN_REMOVE;
    send_request(q);
    q.func = offrt_pkg::func_t'(3'd6);
    send_request(q);
    q.func = offrt_pkg::func_t'(3'd7);
    send_request(q);
    q.func = offrt_pkg::FN_CLEAR;
    send_request(q);
  endtask

  task automatic test_table_full();
    offrt_pkg::req_t q;
    for (int k = 0; k < TABLE_DEPTH + 2; k++)
      send_request(random_request(offrt_pkg::FN_APPEND));
    for (int k = 0; k < 4; k++) send_request(random_request(offrt_pkg::FN_CHECK));
    q = random_request(offrt_pkg::FN_REMOVE);
    q.rule_control[offrt_pkg::C_IDX +: offrt_pkg::IDX_W] = 6'h3f;
    send_request(q);
    q.rule_control[offrt_pkg::C_IDX +: offrt_pkg::IDX_W] = '0;
    send_request(q);
    send_request(random_request(offrt_pkg::FN_CHECK));
    send_request(random_request(offrt_pkg::FN_CLEAR));
  endtask

  task automatic test_random_mix(int unsigned n);
    offrt_pkg::func_t f;
    int unsigned r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) f = offrt_pkg::FN_CHECK;
      else if (r < 70) f = (shadow_count < 12) ? offrt_pkg::FN_APPEND : offrt_pkg::FN_OVER;
      else if (r < 80) f = offrt_pkg::FN_OVER;
      else if (r < 88) f = offrt_pkg::FN_ENABLE;
      else if (r < 96) f = offrt_pkg::FN_REMOVE;
      else if (r < 98) f = offrt_pkg::FN_CLEAR;
      else f = offrt_pkg::func_t'($urandom_range(6, 7));
      begin
        offrt_pkg::req_t q;
        q = random_request(f);
        if (f != offrt_pkg::FN_APPEND && shadow_count > 0 && $urandom_range(0, 4) != 0)
          q.rule_control[offrt_pkg::C_IDX +: offrt_pkg::IDX_W] =
            6'($urandom_range(0, shadow_count - 1));
        send_request(q);
      end
    end
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    shadow_count = 0;
    quiet_mode = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed_commands();
    test_table_full();
    test_random_mix(340);
    quiet_mode = 1'b1;
    test_random_mix(60);
    in_if.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (TABLE_DEPTH + 8) @(posedge clk);
    $display("sent %0d requests, checked %0d results, %0d mismatches",
             requests_sent, results_seen, mismatches);
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
`default_nettype wire

@@ sim.f @@
+incdir+hdl
hdl/offrt_pkg.sv
hdl/offrt_if.sv
hdl/ordered_frame_filter_rule_table_top.sv
verif/ordered_frame_filter_rule_table_top_tb.sv
